// ===== rtl/core/float_scale_by_power_of_two_defines.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; included by the checker only.
`ifndef FLOAT_SCALE_BY_POWER_OF_TWO_DEFINES_SVH
`define FLOAT_SCALE_BY_POWER_OF_TWO_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define FSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define FSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/fsp_pkg.sv =====
// Shared constants and types for the power-of-two float scaler.
// No dependencies.
package fsp_pkg;
  typedef enum logic [1:0] {
    ST_EXACT     = 2'd0,
    ST_INEXACT   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_UP      = 2'd1,
    RM_DOWN    = 2'd2,
    RM_ZERO    = 2'd3
  } rmode_t;

  localparam int unsigned PIPE_DEPTH = 4;
endpackage

// ===== rtl/core/float_scale_by_power_of_two.sv =====
// Top level of the power-of-two float scaler (scalbn/ldexp), double or single.
// Depends on fsp_pkg.
//
// channel | ports                                   | handshake
// in      | in_mode, in_x_bits, in_scale_exponent   | start & !busy
// out     | out_result_bits, out_status             | out_valid, one cycle
// cfg     | cfg_we, cfg_wdata                       | cfg_we
//
// out_valid follows accept through the stages below; one word enters every cycle.
// The four stages are: unpack and leading-one search, exponent sum and range
// check, subnormal shift, round and pack. busy is always low since the
// receiver cannot stall. Synchronous reset clears the valid bits and the
// rounding mode.
module float_scale_by_power_of_two (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [63:0] in_x_bits,
  input  logic signed [31:0] in_scale_exponent,
  output logic        out_valid,
  output logic [63:0] out_result_bits,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);
  logic [1:0]                      rm_r;
  logic [fsp_pkg::PIPE_DEPTH-1:0]  v_r;

  assign busy = 1'b0;

  // Hold the rounding mode.
  always_ff @(posedge clk) begin
    if (!rst_n) rm_r <= 2'd0;
    else if (cfg_we) rm_r <= cfg_wdata;
  end

  // Advance the valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[fsp_pkg::PIPE_DEPTH-2:0], start};
  end

  // Stage 1: unpack, classify, normalize significand.
  logic        s1_mode_r, s1_sign_r, s1_pass_r;
  logic [63:0] s1_bits_r;
  logic [52:0] s1_sig_r;
  logic signed [12:0] s1_e_r;
  logic signed [31:0] s1_n_r;

  logic [10:0] ef1;
  logic [51:0] fr1;
  logic        emx1;
  logic [5:0]  top1;
  logic [52:0] sig1;
  logic signed [12:0] e1;
  always_comb begin
    top1 = '0;
    if (in_mode) begin
      ef1  = {3'd0, in_x_bits[30:23]};
      fr1  = {29'd0, in_x_bits[22:0]};
      emx1 = (in_x_bits[30:23] == 8'hff);
    end else begin
      ef1  = in_x_bits[62:52];
      fr1  = in_x_bits[51:0];
      emx1 = (in_x_bits[62:52] == 11'h7ff);
    end
    for (int i = 0; i < 52; i++) if (fr1[i]) top1 = 6'(i);
    if (in_mode) begin
      if (ef1 != '0) begin
        sig1 = {29'd0, 1'b1, fr1[22:0]};
        e1   = 13'(signed'({2'b0, ef1})) - 13'sd127;
      end else begin
        sig1 = 53'({29'd0, fr1[23:0]} << (6'd23 - top1));
        e1   = 13'(signed'({7'b0, top1})) - 13'sd149;
      end
    end else begin
      if (ef1 != '0) begin
        sig1 = {1'b1, fr1};
        e1   = 13'(signed'({2'b0, ef1})) - 13'sd1023;
      end else begin
        sig1 = 53'({1'b0, fr1} << (6'd52 - top1));
        e1   = 13'(signed'({7'b0, top1})) - 13'sd1074;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r <= in_mode;
    s1_sign_r <= in_mode ? in_x_bits[31] : in_x_bits[63];
    s1_pass_r <= emx1 || (ef1 == '0 && fr1 == '0);
    s1_bits_r <= in_mode ? {32'd0, in_x_bits[31:0]} : in_x_bits;
    s1_sig_r  <= sig1;
    s1_e_r    <= e1;
    s1_n_r    <= in_scale_exponent;
  end

  // Stage 2: target exponent and range decisions.
  logic        s2_mode_r, s2_sign_r, s2_pass_r, s2_ovf_r, s2_norm_r;
  logic [63:0] s2_bits_r;
  logic [52:0] s2_sig_r;
  logic [11:0] s2_eb_r;
  logic [6:0]  s2_sh_r;
  logic        s2_big_r;

  logic signed [33:0] tgt2, bias2, shl2;
  always_comb begin
    tgt2  = 34'(s1_e_r) + 34'(s1_n_r);
    bias2 = s1_mode_r ? 34'sd127 : 34'sd1023;
    shl2  = -tgt2 - (bias2 - 34'sd1);
  end

  always_ff @(posedge clk) begin
    s2_mode_r <= s1_mode_r;
    s2_sign_r <= s1_sign_r;
    s2_pass_r <= s1_pass_r;
    s2_bits_r <= s1_bits_r;
    s2_sig_r  <= s1_sig_r;
    s2_ovf_r  <= tgt2 > bias2;
    s2_norm_r <= tgt2 >= (34'sd1 - bias2);
    s2_eb_r   <= 12'(tgt2 + bias2);
    s2_big_r  <= shl2 >= 34'sd64;
    s2_sh_r   <= 7'(shl2);
  end

  // Stage 3: shift the significand into subnormal position.
  logic        s3_mode_r, s3_sign_r, s3_pass_r, s3_ovf_r, s3_norm_r;
  logic [63:0] s3_bits_r;
  logic [52:0] s3_sig_r, s3_q_r;
  logic [11:0] s3_eb_r;
  logic        s3_lost_r, s3_half_r, s3_above_r;

  logic [52:0] q3, rm3;
  logic [52:0] hm3;
  always_comb begin
    if (s2_big_r || s2_sh_r >= 7'd64) begin
      q3 = '0; rm3 = s2_sig_r; hm3 = '0;
    end else begin
      q3  = s2_sig_r >> s2_sh_r;
      rm3 = s2_sig_r & 53'((64'd1 << s2_sh_r) - 64'd1);
      hm3 = (s2_sh_r == 7'd0) ? 53'd0 : 53'(64'd1 << (s2_sh_r - 7'd1));
    end
  end

  always_ff @(posedge clk) begin
    s3_mode_r  <= s2_mode_r;
    s3_sign_r  <= s2_sign_r;
    s3_pass_r  <= s2_pass_r;
    s3_ovf_r   <= s2_ovf_r;
    s3_norm_r  <= s2_norm_r;
    s3_bits_r  <= s2_bits_r;
    s3_sig_r   <= s2_sig_r;
    s3_eb_r    <= s2_eb_r;
    s3_q_r     <= q3;
    s3_lost_r  <= rm3 != '0;
    s3_half_r  <= (hm3 != '0) && (rm3 == hm3);
    s3_above_r <= (hm3 != '0) && (rm3 > hm3);
  end

  // Stage 4: round and pack.
  logic [63:0] res4;
  logic [1:0]  st4;
  logic        inc4;
  logic [53:0] rd4;
  always_comb begin
    inc4 = 1'b0;
    res4 = s3_bits_r;
    st4  = fsp_pkg::ST_EXACT;
    if (s3_lost_r) begin
      case (fsp_pkg::rmode_t'(rm_r))
        fsp_pkg::RM_UP:   inc4 = !s3_sign_r;
        fsp_pkg::RM_DOWN: inc4 = s3_sign_r;
        fsp_pkg::RM_ZERO: inc4 = 1'b0;
        default:          inc4 = s3_above_r || (s3_half_r && s3_q_r[0]);
      endcase
    end
    rd4 = {1'b0, s3_q_r} + 54'(inc4);
    if (s3_pass_r) begin
      res4 = s3_bits_r;
    end else if (s3_mode_r) begin
      if (s3_ovf_r) begin
        res4 = {32'd0, s3_sign_r, 8'hff, 23'd0};
        st4  = fsp_pkg::ST_OVERFLOW;
      end else if (s3_norm_r) begin
        res4 = {32'd0, s3_sign_r, s3_eb_r[7:0], s3_sig_r[22:0]};
      end else if (rd4 >= 54'd1 << 23) begin
        res4 = {32'd0, s3_sign_r, 8'd1, 23'd0};
        if (s3_lost_r) st4 = fsp_pkg::ST_INEXACT;
      end else begin
        res4 = {32'd0, s3_sign_r, 8'd0, rd4[22:0]};
        if (s3_lost_r) st4 = fsp_pkg::ST_UNDERFLOW;
      end
    end else begin
      if (s3_ovf_r) begin
        res4 = {s3_sign_r, 11'h7ff, 52'd0};
        st4  = fsp_pkg::ST_OVERFLOW;
      end else if (s3_norm_r) begin
        res4 = {s3_sign_r, s3_eb_r[10:0], s3_sig_r[51:0]};
      end else if (rd4 >= 54'd1 << 52) begin
        res4 = {s3_sign_r, 11'd1, 52'd0};
        if (s3_lost_r) st4 = fsp_pkg::ST_INEXACT;
      end else begin
        res4 = {s3_sign_r, 11'd0, rd4[51:0]};
        if (s3_lost_r) st4 = fsp_pkg::ST_UNDERFLOW;
      end
    end
  end

  logic [63:0] res_r;
  logic [1:0]  st_r;
  always_ff @(posedge clk) begin
    res_r <= res4;
    st_r  <= st4;
  end

  assign out_valid       = v_r[fsp_pkg::PIPE_DEPTH-1];
  assign out_result_bits = res_r;
  assign out_status      = st_r;
endmodule

// ===== rtl/core/fsp_checker.sv =====
// Port-level checker for the power-of-two float scaler, with its bind.
// Depends on float_scale_by_power_of_two_defines.svh and fsp_pkg.
`include "float_scale_by_power_of_two_defines.svh"
module fsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [63:0] out_result_bits,
  input logic [1:0]  out_status
);
  // A result word shows up only for a word that was taken.
  `FSP_ASSERT_IMPL(a_latency, clk, rst_n, out_valid, $past(start && !busy, 4))
  // Every accepted word comes back.
  `FSP_ASSERT_NEXT(a_word_returns, clk, rst_n, start && !busy, ##3 out_valid)
  // The scaler never stalls its sender.
  `FSP_ASSERT_IMPL(a_never_busy, clk, rst_n, 1'b1, !busy)
  // A result word carries no unknown bits.
  `FSP_ASSERT_IMPL(a_known_result, clk, rst_n, out_valid, !$isunknown({out_result_bits, out_status}))
  // Overflow always yields an infinity in one of the two formats.
  `FSP_ASSERT_IMPL(a_overflow_inf, clk, rst_n, out_valid && out_status == fsp_pkg::ST_OVERFLOW, (out_result_bits[62:0] == 63'h7ff0000000000000) || (out_result_bits[63:32] == 32'd0 && out_result_bits[30:0] == 31'h7f800000))
endmodule

bind float_scale_by_power_of_two fsp_checker u_fsp_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_result_bits(out_result_bits), .out_status(out_status)
);

// ===== sim/tb_top.sv =====
// Testbench for the power-of-two float scaler: directed and random words in
// both formats, random ones in all rounding modes, each result checked against a predictor.
// Depends on fsp_pkg and float_scale_by_power_of_two.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0]      result_bits;
    fsp_pkg::status_t status;
  } scaled_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_mode = 1'b0;
  logic [63:0] in_x_bits = '0;
  logic signed [31:0] in_scale_exponent = '0;
  logic        out_valid;
  logic [63:0] out_result_bits;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;

  fsp_pkg::rmode_t round_mode = fsp_pkg::RM_NEAREST;
  scaled_t pending_q[$];
  int      err_count = 0;
  int      word_count = 0;
  int      checked_count = 0;
  longint  cycle_count = 0;

  float_scale_by_power_of_two dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_x_bits(in_x_bits), .in_scale_exponent(in_scale_exponent),
    .out_valid(out_valid), .out_result_bits(out_result_bits), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shift a significand right, rounding in the current mode.
  function automatic logic [63:0] round_shift(logic [63:0] sig, longint sh,
                                              logic neg, output logic lost);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q = '0;
    rem = '0;
    lost = 1'b0;
    if (sh == 0) return sig;
    if (sh >= 64) begin
      lost = sig != 0;
    end else begin
      q = sig >> sh;
      rem = sig & ((64'd1 << sh) - 1);
      lost = rem != 0;
    end
    if (!lost) return q;
    case (round_mode)
      fsp_pkg::RM_UP: return neg ? q : q + 1;
      fsp_pkg::RM_DOWN: return neg ? q + 1 : q;
      fsp_pkg::RM_ZERO: return q;
      default: begin
        if (sh < 64) begin
          half = 64'd1 << (sh - 1);
          if (rem > half || (rem == half && q[0])) q = q + 1;
        end
        return q;
      end
    endcase
  endfunction

  // Predict x * 2^n for one word.
  function automatic scaled_t scale_value(logic single, logic [63:0] x,
                                          logic signed [31:0] n);
    scaled_t r;
    int fb;
    int eb;
    longint bias;
    logic [63:0] bits;
    logic [63:0] sgn;
    logic [63:0] emax;
    logic [63:0] fmask;
    logic [63:0] ef;
    logic [63:0] frac;
    logic [63:0] sig;
    logic [63:0] rd;
    longint e;
    longint target;
    int top;
    logic lost;
    fb = single ? 23 : 52;
    eb = single ? 8 : 11;
    bias = single ? 127 : 1023;
    bits = single ? {32'd0, x[31:0]} : x;
    sgn = bits & (64'd1 << (fb + eb));
    emax = (64'd1 << eb) - 1;
    fmask = (64'd1 << fb) - 1;
    ef = (bits >> fb) & emax;
    frac = bits & fmask;
    r.status = fsp_pkg::ST_EXACT;
    r.result_bits = bits;
    if (ef == emax || (ef == 0 && frac == 0)) return r;
    if (ef != 0) begin
      sig = (64'd1 << fb) | frac;
      e = longint'(ef) - bias;
    end else begin
      top = 0;
      for (int i = 0; i < 64; i++) if (frac[i]) top = i;
      sig = frac << (fb - top);
      e = top - (bias + fb - 1);
    end
    target = e + longint'(n);
    if (target > bias) begin
      r.status = fsp_pkg::ST_OVERFLOW;
      r.result_bits = sgn | (emax << fb);
    end else if (target >= 1 - bias) begin
      r.result_bits = sgn | (64'(target + bias) << fb) | (sig & fmask);
    end else begin
      rd = round_shift(sig, -target - (bias - 1), sgn != 0, lost);
      if (rd >= (64'd1 << fb)) begin
        if (lost) r.status = fsp_pkg::ST_INEXACT;
        r.result_bits = sgn | (64'd1 << fb);
      end else begin
        if (lost) r.status = fsp_pkg::ST_UNDERFLOW;
        r.result_bits = sgn | rd;
      end
    end
    return r;
  endfunction

  // Check each result word against the oldest prediction.
  always @(posedge clk) begin
    scaled_t exp_w;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("result word with no prediction waiting");
        err_count++;
      end else begin
        exp_w = pending_q.pop_front();
        checked_count++;
        if (out_result_bits !== exp_w.result_bits) begin
          $error("result_bits expected %h actual %h", exp_w.result_bits, out_result_bits);
          err_count++;
        end
        if (out_status !== exp_w.status) begin
          $error("status expected %0d actual %0d", exp_w.status, out_status);
          err_count++;
        end
      end
    end
  end

  // Abort on a hang.
  always @(posedge clk) begin
    if (cycle_count > 200000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one word after an optional gap; predict at acceptance.
  // start stays high afterwards so the next word can follow at once.
  task automatic send_word(logic single, logic [63:0] x, logic signed [31:0] n,
                           int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= single;
    in_x_bits <= x;
    in_scale_exponent <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(scale_value(single, x, n));
    word_count++;
  endtask

  // Drop start and wait until every expected result has come.
  task automatic drain_words();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Wait for the pipe to drain, then write the rounding mode.
  task automatic set_round_mode(fsp_pkg::rmode_t m);
    drain_words();
    repeat (fsp_pkg::PIPE_DEPTH + 2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    round_mode = m;
  endtask

  function automatic logic signed [31:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 400)) - 200;
      default: return $signed($urandom_range(0, 2400)) - 1200;
    endcase
  endfunction

  function automatic logic [63:0] rand_operand(logic single);
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: if (single) v[30:23] = 8'd0; else v[62:52] = 11'd0;
      1: if (single) v[30:23] = 8'hff; else v[62:52] = 11'h7ff;
      2: if (single) v[30:0] = 31'd0; else v[62:0] = 63'd0;
      default: ;
    endcase
    return v;
  endfunction

  // Special values, extremes of the scale and both formats.
  task automatic test_directed();
    send_word(1'b0, 64'h0, 32'sd5, 0);
    send_word(1'b0, 64'h8000000000000000, 32'sh7fffffff, 0);
    send_word(1'b0, 64'h7ff0000000000000, -32'sd3, 0);
    send_word(1'b0, 64'hfff8000000000001, 32'sd7, 0);
    send_word(1'b0, 64'h0000000000000001, 32'sd1074, 0);
    send_word(1'b0, 64'h000fffffffffffff, 32'sd1, 0);
    send_word(1'b0, 64'h3ff0000000000000, 32'sd1024, 0);
    send_word(1'b0, 64'hbff0000000000000, 32'sh7fffffff, 0);
    send_word(1'b0, 64'h3ff0000000000000, -32'sd1074, 0);
    send_word(1'b0, 64'h3ff8000000000000, -32'sd1075, 0);
    send_word(1'b0, 64'hbfffffffffffffff, -32'sd1023, 0);
    send_word(1'b0, 64'hffffffffffffffff, 32'sh80000000, 0);
    send_word(1'b0, 64'h7fefffffffffffff, -32'sd1, 0);
    send_word(1'b1, 64'hffffffff3f800000, 32'sd128, 0);
    send_word(1'b1, 64'h00000000bf800000, -32'sd149, 0);
    send_word(1'b1, 64'h0000000000000001, 32'sd149, 0);
    send_word(1'b1, 64'h123456787f800000, 32'sd2, 0);
    send_word(1'b1, 64'h00000000ffc00001, 32'sd2, 0);
    send_word(1'b1, 64'h0000000080000000, -32'sd9, 0);
    send_word(1'b1, 64'h000000003fffffff, -32'sd126, 0);
    send_word(1'b1, 64'h00000000007fffff, 32'sh80000000, 0);
  endtask

  // Random words with random gaps; the first 30 of every 100 words go without gaps.
  task automatic test_random(int count);
    logic single;
    for (int i = 0; i < count; i++) begin
      single = $urandom_range(0, 1);
      send_word(single, rand_operand(single), rand_scale(),
                (i % 100 < 30) ? 0 : $urandom_range(0, 6));
    end
  endtask

  // Values near the subnormal border in one rounding mode.
  task automatic test_rounding();
    logic single;
    logic signed [31:0] n;
    for (int i = 0; i < 40; i++) begin
      single = $urandom_range(0, 1);
      n = single ? -32'sd126 - $signed($urandom_range(0, 30))
                 : -32'sd1022 - $signed($urandom_range(0, 60));
      send_word(single, rand_operand(single), n, $urandom_range(0, 6));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    // Hold the sender until every result has come back.
    drain_words();
    test_rounding();
    test_random(200);
    set_round_mode(fsp_pkg::RM_UP);
    test_directed();
    test_rounding();
    test_random(200);
    set_round_mode(fsp_pkg::RM_DOWN);
    test_rounding();
    test_random(200);
    set_round_mode(fsp_pkg::RM_ZERO);
    test_directed();
    test_rounding();
    test_random(200);
    set_round_mode(fsp_pkg::RM_NEAREST);
    test_rounding();
    test_random(100);
    start <= 1'b0;
    while (pending_q.size() != 0 && cycle_count < 200000) @(posedge clk);
    repeat (fsp_pkg::PIPE_DEPTH + 4) @(posedge clk);
    $display("Sent %0d words in both formats over all four rounding modes;", word_count);
    $display("checked %0d results, %0d mismatches.", checked_count, err_count);
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
